// ===== sv/cst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants of the card sector translator
// Opcodes, sequencer states and the result word passed to the output stage.
// ----------------------------------------------------------------------------
package cst_pkg;

    // fixed field widths
    localparam int SECTOR_W = 10;
    localparam int VALUE_W  = 11;
    localparam int INDEX_W  = 5;
    localparam int START_W  = 4;

    // remapped sectors start at this offset plus the broken-table size
    localparam int REMAP_BASE_OFS = 16;

    // item opcodes (code 3 is ignored)
    typedef enum logic [1:0] {
        OP_WR_LINK   = 2'd0,
        OP_WR_BROKEN = 2'd1,
        OP_XLATE     = 2'd2
    } t_op;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HOP_RD,
        ST_HOP_WAIT,
        ST_SUM,
        ST_SEARCH,
        ST_DONE
    } t_state;

    // one translation result
    typedef struct packed {
        logic                chain_error;
        logic                remapped;
        logic [SECTOR_W-1:0] physical_sector;
        logic [SECTOR_W-1:0] absolute_sector;
    } t_result;

endpackage

// ===== sv/cst_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/cst_vtable.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_vtable: table RAM with a valid bit per entry
// Reset clears all valid bits at once; an invalid entry reads with
// o_rvalid low so the user substitutes the reset value.
// ----------------------------------------------------------------------------
module cst_vtable #(
    parameter int WIDTH = 8,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_wvalid,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_rvalid
);

    localparam int DEPTH = 2 ** AW;

    logic [DEPTH-1:0] r_valid;
    logic             r_rvalid;

    // valid bits: cleared by reset, written with each entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= i_wvalid;
        end
    end

    // valid bit follows the registered read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid <= 1'b0;
        end else if (i_re) begin
            r_rvalid <= r_valid[i_raddr];
        end
    end

    cst_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_re    (i_re),
        .i_raddr (i_raddr),
        .o_rdata (o_rdata)
    );

    assign o_rvalid = r_rvalid;

endmodule

// ===== sv/cst_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_ctrl: translation sequencer
// Takes table writes while idle; walks the link chain one hop per read and
// wait state, forms the absolute sector, then scans the broken table one entry
// per cycle through its read port.
// ----------------------------------------------------------------------------
module cst_ctrl #(
    parameter int DIR_ENTRIES       = 15,
    parameter int BROKEN_ENTRIES    = 20,
    parameter int SECTORS_PER_BLOCK = 64,
    parameter int PORTS             = 2,
    localparam int PW  = (PORTS > 1) ? $clog2(PORTS) : 1,
    localparam int BW  = $clog2(DIR_ENTRIES),
    localparam int BIW = (BROKEN_ENTRIES > 1) ? $clog2(BROKEN_ENTRIES) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // item in
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_opcode,
    input  logic                         i_card_port,
    input  logic [cst_pkg::INDEX_W-1:0]  i_entry_index,
    input  logic [cst_pkg::VALUE_W-1:0]  i_entry_value,
    input  logic [cst_pkg::START_W-1:0]  i_start_block,
    input  logic [cst_pkg::SECTOR_W-1:0] i_relative_sector,
    // link table
    output logic                         o_lnk_we,
    output logic [PW+BW-1:0]             o_lnk_waddr,
    output logic [BW:0]                  o_lnk_wdata,
    output logic                         o_lnk_re,
    output logic [PW+BW-1:0]             o_lnk_raddr,
    input  logic [BW:0]                  i_lnk_rdata,
    input  logic                         i_lnk_rvalid,
    // broken table
    output logic                         o_brk_we,
    output logic [PW+BIW-1:0]            o_brk_waddr,
    output logic [cst_pkg::SECTOR_W-1:0] o_brk_wdata,
    output logic                         o_brk_wvalid,
    output logic                         o_brk_re,
    output logic [PW+BIW-1:0]            o_brk_raddr,
    input  logic [cst_pkg::SECTOR_W-1:0] i_brk_rdata,
    input  logic                         i_brk_rvalid,
    // result out
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output cst_pkg::t_result             o_res
);

    localparam int CW    = $clog2(BROKEN_ENTRIES + 1);
    localparam int ABS_W = 20;
    localparam logic [cst_pkg::SECTOR_W-1:0] SPB_V = cst_pkg::SECTOR_W'(SECTORS_PER_BLOCK);
    localparam logic [cst_pkg::SECTOR_W-1:0] REMAP_BASE =
        cst_pkg::SECTOR_W'(cst_pkg::REMAP_BASE_OFS + BROKEN_ENTRIES);

    cst_pkg::t_state r_state, n_state;

    logic [cst_pkg::SECTOR_W-1:0] r_sector, n_sector;
    logic [BW-1:0]                r_block, n_block;
    logic [PW-1:0]                r_port, n_port;
    logic [ABS_W-1:0]             r_abs, n_abs;
    logic [CW-1:0]                r_idx, n_idx;
    logic                         r_pend, n_pend;
    logic [BIW-1:0]               r_rdidx, n_rdidx;
    logic                         r_err, n_err;
    logic                         r_hit, n_hit;
    logic [cst_pkg::SECTOR_W-1:0] r_phys, n_phys;

    logic                         w_accept;
    logic [PW:0]                  w_port_ext;
    logic [6:0]                   w_idx_ext;
    logic [6:0]                   w_start_ext;
    logic                         w_port_ok;
    logic                         w_lnk_in_range;
    logic                         w_more_hops;
    logic                         w_issue;
    logic                         w_match;

    // field decode
    assign w_accept       = i_in_valid && o_in_ready;
    assign w_port_ext     = (PW + 1)'(i_card_port);
    assign w_idx_ext      = 7'(i_entry_index);
    assign w_start_ext    = 7'(i_start_block);
    assign w_port_ok      = 32'(i_card_port) < PORTS;
    assign w_lnk_in_range = !i_entry_value[cst_pkg::VALUE_W-1]
                            && (32'(i_entry_value[cst_pkg::SECTOR_W-1:0]) < DIR_ENTRIES);
    assign w_more_hops    = r_sector >= SPB_V;
    assign w_issue        = 32'(r_idx) < BROKEN_ENTRIES;
    assign w_match        = r_pend && i_brk_rvalid && (r_abs == ABS_W'(i_brk_rdata));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cst_pkg::ST_IDLE: begin
                if (w_accept && i_opcode == cst_pkg::OP_XLATE) begin
                    if (!w_port_ok || 32'(i_start_block) >= DIR_ENTRIES) begin
                        n_state = cst_pkg::ST_DONE;
                    end else begin
                        n_state = cst_pkg::ST_HOP_RD;
                    end
                end
            end
            cst_pkg::ST_HOP_RD: begin
                n_state = w_more_hops ? cst_pkg::ST_HOP_WAIT : cst_pkg::ST_SUM;
            end
            cst_pkg::ST_HOP_WAIT: begin
                if (i_lnk_rvalid && i_lnk_rdata[BW]) begin
                    n_state = cst_pkg::ST_DONE;
                end else begin
                    n_state = cst_pkg::ST_HOP_RD;
                end
            end
            cst_pkg::ST_SUM: begin
                n_state = cst_pkg::ST_SEARCH;
            end
            cst_pkg::ST_SEARCH: begin
                if (w_match || (!r_pend && !w_issue)) begin
                    n_state = cst_pkg::ST_DONE;
                end
            end
            cst_pkg::ST_DONE: begin
                if (i_res_ready) begin
                    n_state = cst_pkg::ST_IDLE;
                end
            end
            default: n_state = cst_pkg::ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_sector = r_sector;
        n_block  = r_block;
        n_port   = r_port;
        n_abs    = r_abs;
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_rdidx  = r_rdidx;
        n_err    = r_err;
        n_hit    = r_hit;
        n_phys   = r_phys;
        unique case (r_state)
            cst_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_sector = i_relative_sector;
                    n_block  = w_start_ext[BW-1:0];
                    n_port   = w_port_ext[PW-1:0];
                    n_err    = !w_port_ok || 32'(i_start_block) >= DIR_ENTRIES;
                    n_hit    = 1'b0;
                end
            end
            cst_pkg::ST_HOP_WAIT: begin
                // one hop: take a block off the remaining sector
                n_sector = r_sector - SPB_V;
                if (i_lnk_rvalid && i_lnk_rdata[BW]) begin
                    n_err = 1'b1;
                end else begin
                    n_block = i_lnk_rvalid ? i_lnk_rdata[BW-1:0] : '0;
                end
            end
            cst_pkg::ST_SUM: begin
                n_abs  = ABS_W'(r_block) * ABS_W'(SECTORS_PER_BLOCK)
                         + ABS_W'(r_sector) + ABS_W'(SECTORS_PER_BLOCK);
                n_idx  = '0;
                n_pend = 1'b0;
            end
            cst_pkg::ST_SEARCH: begin
                // issue next read, check the one returned
                n_pend = w_issue && !w_match;
                if (w_issue) begin
                    n_idx   = r_idx + CW'(1);
                    n_rdidx = r_idx[BIW-1:0];
                end
                if (w_match) begin
                    n_hit  = 1'b1;
                    n_phys = REMAP_BASE + cst_pkg::SECTOR_W'(r_rdidx);
                end
            end
            cst_pkg::ST_HOP_RD, cst_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready   = r_state == cst_pkg::ST_IDLE;
        o_lnk_we     = w_accept && i_opcode == cst_pkg::OP_WR_LINK && w_port_ok
                       && 32'(i_entry_index) < DIR_ENTRIES;
        o_lnk_waddr  = {w_port_ext[PW-1:0], w_idx_ext[BW-1:0]};
        o_lnk_wdata  = w_lnk_in_range ? {1'b0, i_entry_value[BW-1:0]} : {1'b1, BW'(0)};
        o_lnk_re     = r_state == cst_pkg::ST_HOP_RD && w_more_hops;
        o_lnk_raddr  = {r_port, r_block};
        o_brk_we     = w_accept && i_opcode == cst_pkg::OP_WR_BROKEN && w_port_ok
                       && 32'(i_entry_index) < BROKEN_ENTRIES;
        o_brk_waddr  = {w_port_ext[PW-1:0], w_idx_ext[BIW-1:0]};
        o_brk_wdata  = i_entry_value[cst_pkg::SECTOR_W-1:0];
        o_brk_wvalid = !i_entry_value[cst_pkg::VALUE_W-1];
        o_brk_re     = r_state == cst_pkg::ST_SEARCH && w_issue;
        o_brk_raddr  = {r_port, r_idx[BIW-1:0]};
        o_res_valid  = r_state == cst_pkg::ST_DONE;
        o_res.chain_error     = r_err;
        o_res.remapped        = r_hit && !r_err;
        o_res.absolute_sector = r_err ? '0 : r_abs[cst_pkg::SECTOR_W-1:0];
        o_res.physical_sector = r_err ? '0 :
                                (r_hit ? r_phys : r_abs[cst_pkg::SECTOR_W-1:0]);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cst_pkg::ST_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_sector <= n_sector;
        r_block  <= n_block;
        r_port   <= n_port;
        r_abs    <= n_abs;
        r_idx    <= n_idx;
        r_rdidx  <= n_rdidx;
        r_err    <= n_err;
        r_hit    <= n_hit;
        r_phys   <= n_phys;
    end

    // each hop takes exactly one block off the remaining sector
    a_hop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cst_pkg::ST_HOP_WAIT) |=> (r_sector == $past(r_sector) - SPB_V))
        else $error("hop did not consume one block");

    // a chain error result carries no sector
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.chain_error) |->
        (o_res.absolute_sector == '0 && o_res.physical_sector == '0 && !o_res.remapped))
        else $error("chain error with nonzero sector");

    // a remapped sector lies in the spare area
    a_remap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.remapped) |-> (o_res.physical_sector >= REMAP_BASE))
        else $error("remapped sector below spare area");

    // no broken-table read returns for an index past the table
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cst_pkg::ST_SEARCH && r_pend) |-> (32'(r_rdidx) < BROKEN_ENTRIES))
        else $error("broken-table scan past end");

    // the chain walk stops once the sector is inside one block
    a_walk_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cst_pkg::ST_SUM) |-> (r_sector < SPB_V))
        else $error("walk ended with sector beyond a block");

endmodule

// ===== sv/card_sector_translator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// card_sector_translator: memory card sector translation with bad-sector remap
// Per card port a next-block link table and a broken-sector table; items
// write either table or translate a file-relative sector.
//
//   channel   dir  tdata (low bit first)                          tuser
//   s_axis    in   card_port, entry_index, entry_value,           opcode
//                  start_block, relative_sector, pad to 32
//   m_axis    out  absolute_sector, physical_sector, pad to 24    remapped, chain_error
//
// Table writes and ignored opcodes leave the sequencer idle, so a new word is
// taken in the next cycle. A translation walks the link chain hop by hop
// through the link-table read port, forms the absolute sector, then scans the
// broken table entry by entry through the broken-table read port and drains
// the last read, stopping early on a match; a bad start block or port goes
// straight to the result.
// Reset is synchronous; it clears the valid bits of both tables at once, so
// no clearing pass is needed. The result sits in an output register; a stalled
// m_axis holds the sequencer in its final state until that register frees.
// ----------------------------------------------------------------------------
module card_sector_translator #(
    parameter int DIR_ENTRIES       = 15,
    parameter int BROKEN_ENTRIES    = 20,
    parameter int SECTORS_PER_BLOCK = 64,
    parameter int PORTS             = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // card_port, entry_index, entry_value,
                                        // start_block, relative_sector
    input  logic [1:0]  s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // absolute_sector, physical_sector
    output logic [1:0]  m_axis_tuser    // remapped, chain_error
);

    localparam int PW  = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int BW  = $clog2(DIR_ENTRIES);
    localparam int BIW = (BROKEN_ENTRIES > 1) ? $clog2(BROKEN_ENTRIES) : 1;

    logic                         w_lnk_we, w_lnk_re, w_lnk_rvalid;
    logic [PW+BW-1:0]             w_lnk_waddr, w_lnk_raddr;
    logic [BW:0]                  w_lnk_wdata, w_lnk_rdata;
    logic                         w_brk_we, w_brk_wvalid, w_brk_re, w_brk_rvalid;
    logic [PW+BIW-1:0]            w_brk_waddr, w_brk_raddr;
    logic [cst_pkg::SECTOR_W-1:0] w_brk_wdata, w_brk_rdata;
    logic                         w_res_valid, w_res_ready;
    cst_pkg::t_result             w_res;
    logic                         r_m_valid;
    cst_pkg::t_result             r_m_res;

    cst_ctrl #(
        .DIR_ENTRIES       (DIR_ENTRIES),
        .BROKEN_ENTRIES    (BROKEN_ENTRIES),
        .SECTORS_PER_BLOCK (SECTORS_PER_BLOCK),
        .PORTS             (PORTS)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (s_axis_tvalid),
        .o_in_ready        (s_axis_tready),
        .i_opcode          (s_axis_tuser),
        .i_card_port       (s_axis_tdata[0]),
        .i_entry_index     (s_axis_tdata[5:1]),
        .i_entry_value     (s_axis_tdata[16:6]),
        .i_start_block     (s_axis_tdata[20:17]),
        .i_relative_sector (s_axis_tdata[30:21]),
        .o_lnk_we          (w_lnk_we),
        .o_lnk_waddr       (w_lnk_waddr),
        .o_lnk_wdata       (w_lnk_wdata),
        .o_lnk_re          (w_lnk_re),
        .o_lnk_raddr       (w_lnk_raddr),
        .i_lnk_rdata       (w_lnk_rdata),
        .i_lnk_rvalid      (w_lnk_rvalid),
        .o_brk_we          (w_brk_we),
        .o_brk_waddr       (w_brk_waddr),
        .o_brk_wdata       (w_brk_wdata),
        .o_brk_wvalid      (w_brk_wvalid),
        .o_brk_re          (w_brk_re),
        .o_brk_raddr       (w_brk_raddr),
        .i_brk_rdata       (w_brk_rdata),
        .i_brk_rvalid      (w_brk_rvalid),
        .o_res_valid       (w_res_valid),
        .i_res_ready       (w_res_ready),
        .o_res             (w_res)
    );

    // link table: next block per entry, top bit marks an invalid link (chain error)
    cst_vtable #(
        .WIDTH (BW + 1),
        .AW    (PW + BW)
    ) u_link_tbl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (w_lnk_we),
        .i_waddr  (w_lnk_waddr),
        .i_wdata  (w_lnk_wdata),
        .i_wvalid (1'b1),
        .i_re     (w_lnk_re),
        .i_raddr  (w_lnk_raddr),
        .o_rdata  (w_lnk_rdata),
        .o_rvalid (w_lnk_rvalid)
    );

    // broken table: valid bit set only for a real broken sector
    cst_vtable #(
        .WIDTH (cst_pkg::SECTOR_W),
        .AW    (PW + BIW)
    ) u_broken_tbl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (w_brk_we),
        .i_waddr  (w_brk_waddr),
        .i_wdata  (w_brk_wdata),
        .i_wvalid (w_brk_wvalid),
        .i_re     (w_brk_re),
        .i_raddr  (w_brk_raddr),
        .o_rdata  (w_brk_rdata),
        .o_rvalid (w_brk_rvalid)
    );

    // output register
    assign w_res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_m_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_m_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {4'b0, r_m_res.physical_sector, r_m_res.absolute_sector};
    assign m_axis_tuser  = {r_m_res.chain_error, r_m_res.remapped};

endmodule
